>>> src/yb2r_pkg.sv
package yb2r_pkg;

  // Fixed-point format of the chroma terms: value * 65536, signed.
  localparam int FracBits  = 16;
  localparam int TermW     = 25;
  localparam int SumW      = 27;
  localparam longint CoefScale = 10000;
  localparam longint CoefVr = 14020;
  localparam longint CoefVg = -7141;
  localparam longint CoefUg = -3441;
  localparam longint CoefUb = 17720;

  typedef logic signed [TermW-1:0] term_t;
  typedef logic signed [SumW-1:0]  sum_t;
  typedef term_t                   rom_t [256];

  // Pixel order inside a 2x2 block.
  typedef enum logic [1:0] {
    POS_TL = 2'd0,
    POS_TR = 2'd1,
    POS_BL = 2'd2,
    POS_BR = 2'd3
  } pix_pos_t;

  // Builds trunc(k * 65536 * c / 10000) for every chroma byte pattern,
  // where c is the byte read as a signed value.
  function automatic rom_t build_rom(input longint k);
    rom_t   rom;
    longint c;
    longint prod;
    for (int i = 0; i < 256; i++) begin
      c        = (i >= 128) ? longint'(i) - 256 : longint'(i);
      prod     = (k * 65536 * c) / CoefScale;
      rom[i]   = term_t'(prod);
    end
    return rom;
  endfunction

  localparam rom_t VrRom = build_rom(CoefVr);
  localparam rom_t VgRom = build_rom(CoefVg);
  localparam rom_t UgRom = build_rom(CoefUg);
  localparam rom_t UbRom = build_rom(CoefUb);

endpackage

>>> src/yb2r_color.sv
module yb2r_color
  import yb2r_pkg::*;
(
  input  logic [7:0] luma,
  input  logic [7:0] chroma_u,
  input  logic [7:0] chroma_v,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);

  sum_t luma_ext;
  sum_t red_sum;
  sum_t green_sum;
  sum_t blue_sum;

  // Clamps a floored 11-bit value to 0..255.
  function automatic logic [7:0] clamp8(input logic signed [SumW-FracBits-1:0] s);
    logic [7:0] r;
    if (s[SumW-FracBits-1]) begin
      r = 8'd0;
    end else if (s[SumW-FracBits-2:8] != '0) begin
      r = 8'hFF;
    end else begin
      r = s[7:0];
    end
    return r;
  endfunction

  // Luma in the same fixed-point scale as the chroma terms.
  assign luma_ext = sum_t'({3'b000, luma, 16'h0000});

  assign red_sum   = luma_ext + sum_t'(VrRom[chroma_v]);
  assign green_sum = luma_ext + sum_t'(UgRom[chroma_u]) + sum_t'(VgRom[chroma_v]);
  assign blue_sum  = luma_ext + sum_t'(UbRom[chroma_u]);

  // Taking the upper bits is an arithmetic shift, which floors.
  assign red   = clamp8(red_sum[SumW-1:FracBits]);
  assign green = clamp8(green_sum[SumW-1:FracBits]);
  assign blue  = clamp8(blue_sum[SumW-1:FracBits]);

endmodule

>>> src/yuv4_block_to_rgb.sv
// Channel  Direction  tdata                                  tuser           tlast
// s_axis   in         u, v, luma tl, tr, bl, br (48 bits)    right_present   -
// m_axis   out        red, green, blue (24 bits)             pixel_position  last
//
// One block yields four pixels (two at an odd-width right edge), one pixel per
// cycle while the output is not stalled, through the single result register.
// A new block is accepted in the cycle the last pixel of the previous block
// enters the result register, so blocks follow each other without a gap.
// Reset clears the block and result valid flags; payload registers are not reset.
// A stalled output holds its pixel and the block register simply waits.
module yuv4_block_to_rgb
  import yb2r_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // chroma_u, chroma_v, luma_top_left, luma_top_right,
                                 // luma_bottom_left, luma_bottom_right
  input  logic        s_tuser,   // right_present
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // red, green, blue
  output logic [1:0]  m_tuser,   // pixel_position
  output logic        m_tlast
);

  // Block register
  logic        blk_valid;
  logic [7:0]  blk_u;
  logic [7:0]  blk_v;
  logic [7:0]  blk_luma [4];
  logic        blk_right;
  pix_pos_t    pos;

  logic        out_load;
  logic        pix_last;
  logic        in_accept;
  pix_pos_t    pos_next;
  logic [7:0]  pix_red;
  logic [7:0]  pix_green;
  logic [7:0]  pix_blue;

  // Pixel sequencing: load the result register whenever it is free or draining.
  assign out_load  = blk_valid && (!m_tvalid || m_tready);
  assign pix_last  = (pos == POS_BR) || ((pos == POS_BL) && !blk_right);
  assign s_tready  = !blk_valid || (out_load && pix_last);
  assign in_accept = s_tvalid && s_tready;

  // Skip the right column when it is absent.
  always_comb begin
    unique case (pos)
      POS_TL:  pos_next = blk_right ? POS_TR : POS_BL;
      POS_TR:  pos_next = POS_BL;
      POS_BL:  pos_next = POS_BR;
      default: pos_next = POS_TL;
    endcase
  end

  // Block control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      blk_valid <= 1'b0;
      pos       <= POS_TL;
    end else if (in_accept) begin
      blk_valid <= 1'b1;
      pos       <= POS_TL;
    end else if (out_load) begin
      blk_valid <= !pix_last;
      pos       <= pos_next;
    end
  end

  // Block payload.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      blk_u       <= s_tdata[7:0];
      blk_v       <= s_tdata[15:8];
      blk_luma[0] <= s_tdata[23:16];
      blk_luma[1] <= s_tdata[31:24];
      blk_luma[2] <= s_tdata[39:32];
      blk_luma[3] <= s_tdata[47:40];
      blk_right   <= s_tuser;
    end
  end

  // Color conversion of the current pixel.
  yb2r_color u_color (
    .luma     (blk_luma[pos]),
    .chroma_u (blk_u),
    .chroma_v (blk_v),
    .red      (pix_red),
    .green    (pix_green),
    .blue     (pix_blue)
  );

  // Result register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {pix_blue, pix_green, pix_red};
      m_tuser <= pos;
      m_tlast <= pix_last;
    end
  end

`ifndef SYNTHESIS
  // The last pixel of a block is never in the top row.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tlast && (m_tuser == POS_TL || m_tuser == POS_TR)))
    else $error("last flag on a top-row pixel");

  // An accepted block starts at the top-left pixel.
  assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (blk_valid && pos == POS_TL))
    else $error("accepted block does not start at top-left");

  // A pixel that is not last leaves its block still pending.
  assert property (@(posedge clk) disable iff (rst)
    (out_load && !pix_last) |=> blk_valid)
    else $error("block dropped before its last pixel");

  // Right-column pixels only come from blocks with a right column.
  assert property (@(posedge clk) disable iff (rst)
    (out_load && (pos == POS_TR || pos == POS_BR)) |-> blk_right)
    else $error("right pixel emitted at an odd-width edge");
`endif

endmodule
